[hw/rtl/tcw_pkg.sv]
// Shared types and constants for the text console writer.
// Used by tcw_ctrl, tcw_datapath and text_console_writer; depends on nothing.
`default_nettype none

package tcw_pkg;

  localparam int unsigned TCW_COLUMNS = 80;
  localparam int unsigned TCW_ROWS    = 25;

  // Command codes carried by an input item.
  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [7:0]  CODE_NEWLINE   = 8'd10;
  localparam logic [7:0]  CODE_BACKSPACE = 8'd8;
  localparam logic [7:0]  CODE_SPACE     = 8'd32;
  localparam logic [15:0] ATTR_MASK      = 16'hFF00;

  typedef enum logic [1:0] {
    SWEEP_INIT,
    SWEEP_CLEAR,
    SWEEP_SCROLL
  } sweep_mode_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_RESULT
  } tcw_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        latch_in;
    logic        new_line;
    logic        back_step;
    logic        col_inc;
    logic        home;
    logic        sweep_start;
    sweep_mode_t sweep_mode;
    logic        rd_index;
    logic        rd_cursor;
    logic        wr_cursor;
    logic        load_out;
  } tcw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] cmd;
    logic       is_newline;
    logic       is_backspace;
    logic       col_zero;
    logic       row_zero;
    logic       col_full;
    logic       row_last;
    logic       sweep_busy;
    logic       out_free;
  } tcw_status_t;

endpackage

`default_nettype wire

[hw/rtl/tcw_ctrl.sv]
// Controller state machine of the text console writer.
// Depends on tcw_pkg; drives tcw_datapath through tcw_cmd_t.
`default_nettype none

module tcw_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire tcw_pkg::tcw_status_t st,
  output tcw_pkg::tcw_cmd_t        cmd
);

  tcw_pkg::tcw_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcw_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_stall  = (state_r != tcw_pkg::ST_IDLE);
    case (state_r)
      tcw_pkg::ST_INIT: begin
        // The store is zeroed by a sweep that starts out of reset.
        if (!st.sweep_busy) begin
          state_nxt = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = tcw_pkg::ST_EXEC;
        end
      end
      tcw_pkg::ST_EXEC: begin
        case (st.cmd)
          tcw_pkg::CMD_PUT: begin
            if (st.is_newline) begin
              cmd.new_line = 1'b1;
              if (st.row_last) begin
                cmd.sweep_start = 1'b1;
                cmd.sweep_mode  = tcw_pkg::SWEEP_SCROLL;
                state_nxt       = tcw_pkg::ST_SWEEP;
              end else begin
                state_nxt = tcw_pkg::ST_RESULT;
              end
            end else if (st.is_backspace) begin
              if (st.col_zero && st.row_zero) begin
                state_nxt = tcw_pkg::ST_RESULT;
              end else begin
                cmd.back_step = 1'b1;
                state_nxt     = tcw_pkg::ST_RMW_RD;
              end
            end else if (st.col_full) begin
              // A full line wraps before the byte is written.
              cmd.new_line = 1'b1;
              if (st.row_last) begin
                cmd.sweep_start = 1'b1;
                cmd.sweep_mode  = tcw_pkg::SWEEP_SCROLL;
                state_nxt       = tcw_pkg::ST_SWEEP;
              end else begin
                state_nxt = tcw_pkg::ST_RMW_RD;
              end
            end else begin
              state_nxt = tcw_pkg::ST_RMW_RD;
            end
          end
          tcw_pkg::CMD_CLEAR: begin
            cmd.home        = 1'b1;
            cmd.sweep_start = 1'b1;
            cmd.sweep_mode  = tcw_pkg::SWEEP_CLEAR;
            state_nxt       = tcw_pkg::ST_SWEEP;
          end
          tcw_pkg::CMD_READ: begin
            cmd.rd_index = 1'b1;
            state_nxt    = tcw_pkg::ST_RESULT;
          end
          default: begin
            state_nxt = tcw_pkg::ST_RESULT;
          end
        endcase
      end
      tcw_pkg::ST_SWEEP: begin
        if (!st.sweep_busy) begin
          if (st.cmd == tcw_pkg::CMD_PUT && !st.is_newline && !st.is_backspace) begin
            state_nxt = tcw_pkg::ST_RMW_RD;
          end else begin
            state_nxt = tcw_pkg::ST_RESULT;
          end
        end
      end
      tcw_pkg::ST_RMW_RD: begin
        cmd.rd_cursor = 1'b1;
        state_nxt     = tcw_pkg::ST_RMW_WR;
      end
      tcw_pkg::ST_RMW_WR: begin
        cmd.wr_cursor = 1'b1;
        cmd.col_inc   = !st.is_backspace;
        state_nxt     = tcw_pkg::ST_RESULT;
      end
      tcw_pkg::ST_RESULT: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = tcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/tcw_datapath.sv]
// Datapath of the text console writer: cell store, cursor, sweep engine
// and result register. Depends on tcw_pkg; commanded by tcw_ctrl.
`default_nettype none

module tcw_datapath #(
  parameter int unsigned COLUMNS = tcw_pkg::TCW_COLUMNS,
  parameter int unsigned ROWS    = tcw_pkg::TCW_ROWS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [1:0]          in_cmd,
  input  wire logic [7:0]          in_char_code,
  input  wire logic [10:0]         in_cell_index,
  input  wire tcw_pkg::tcw_cmd_t   cmd,
  output tcw_pkg::tcw_status_t     st,
  input  wire logic                out_stall,
  output logic                     out_valid,
  output logic [15:0]              out_cell_word,
  output logic [4:0]               out_cursor_row,
  output logic [6:0]               out_cursor_col,
  output logic                     out_scrolled
);

  localparam int unsigned CELLS     = ROWS * COLUMNS;
  localparam int unsigned TOP_CELLS = (ROWS - 1) * COLUMNS;
  localparam int unsigned RW        = $clog2(ROWS);
  localparam int unsigned CW        = $clog2(COLUMNS + 1);
  localparam int unsigned AW        = $clog2(CELLS);

  localparam logic [AW-1:0] COLS_A   = AW'(COLUMNS);
  localparam logic [AW-1:0] LAST_A   = AW'(CELLS - 1);
  localparam logic [AW-1:0] TOP_A    = AW'(TOP_CELLS);
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_FULL = CW'(COLUMNS);
  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);

  logic [1:0]          cmd_r;
  logic [7:0]          code_r;
  logic [10:0]         index_r;

  logic [RW-1:0]       row_r, row_nxt;
  logic [CW-1:0]       col_r, col_nxt;
  logic                scrolled_r, scrolled_nxt;

  logic                sweep_act_r, sweep_act_nxt;
  tcw_pkg::sweep_mode_t sweep_mode_r, sweep_mode_nxt;
  logic [AW-1:0]       ptr_r, ptr_nxt;
  logic                wb_valid_r;
  logic [AW-1:0]       wb_addr_r;
  logic                wb_bottom_r;

  logic [15:0]         cells_r [CELLS];
  logic [15:0]         rdata_r;

  logic                out_valid_r, out_valid_nxt;
  logic [15:0]         cell_word_r;
  logic [4:0]          cursor_row_r;
  logic [6:0]          cursor_col_r;
  logic                out_scrolled_r;

  logic [AW-1:0]       cur_addr;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [15:0]         wr_data;
  logic [7:0]          put_byte;
  logic                idx_ok;

  assign cur_addr = AW'(row_r) * COLS_A + AW'(col_r);
  assign idx_ok   = (32'(index_r) < CELLS);
  assign put_byte = (code_r == tcw_pkg::CODE_BACKSPACE) ? tcw_pkg::CODE_SPACE : code_r;

  // Cursor and scroll flag.
  always_comb begin
    row_nxt      = row_r;
    col_nxt      = col_r;
    scrolled_nxt = scrolled_r;
    if (cmd.home) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (cmd.new_line) begin
      col_nxt = '0;
      if (row_r != ROW_LAST) begin
        row_nxt = row_r + 1'b1;
      end
    end else if (cmd.back_step) begin
      if (col_r == '0) begin
        row_nxt = row_r - 1'b1;
        col_nxt = COL_LAST;
      end else begin
        col_nxt = col_r - 1'b1;
      end
    end else if (cmd.col_inc) begin
      col_nxt = col_r + 1'b1;
    end
    if (cmd.latch_in) begin
      scrolled_nxt = 1'b0;
    end else if (cmd.sweep_start && cmd.sweep_mode == tcw_pkg::SWEEP_SCROLL) begin
      scrolled_nxt = 1'b1;
    end
  end

  // Sweep pointer: one cell read per cycle, written back in the next cycle.
  always_comb begin
    sweep_act_nxt  = sweep_act_r;
    sweep_mode_nxt = sweep_mode_r;
    ptr_nxt        = ptr_r;
    if (cmd.sweep_start) begin
      sweep_act_nxt  = 1'b1;
      sweep_mode_nxt = cmd.sweep_mode;
      ptr_nxt        = '0;
    end else if (sweep_act_r) begin
      ptr_nxt = ptr_r + 1'b1;
      if (ptr_r == LAST_A) begin
        sweep_act_nxt = 1'b0;
      end
    end
  end

  // Read port select.
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = ptr_r;
    if (sweep_act_r) begin
      // A scroll copies each cell from one row below; the bottom row reads itself.
      if (sweep_mode_r == tcw_pkg::SWEEP_SCROLL && ptr_r < TOP_A) begin
        rd_addr = ptr_r + COLS_A;
      end
    end else if (cmd.rd_index) begin
      rd_addr = AW'(index_r);
    end else if (cmd.rd_cursor) begin
      rd_addr = cur_addr;
    end else begin
      rd_en = 1'b0;
    end
  end

  // Write port select.
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = wb_addr_r;
    wr_data = '0;
    if (wb_valid_r) begin
      case (sweep_mode_r)
        tcw_pkg::SWEEP_CLEAR: begin
          wr_data = rdata_r & tcw_pkg::ATTR_MASK;
        end
        tcw_pkg::SWEEP_SCROLL: begin
          wr_data = wb_bottom_r ? ((rdata_r & tcw_pkg::ATTR_MASK) |
                                   {8'h00, tcw_pkg::CODE_SPACE})
                                : rdata_r;
        end
        default: begin
          wr_data = '0;
        end
      endcase
    end else if (cmd.wr_cursor) begin
      wr_addr = cur_addr;
      wr_data = (rdata_r & tcw_pkg::ATTR_MASK) | {8'h00, put_byte};
    end else begin
      wr_en = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r        <= '0;
      col_r        <= '0;
      scrolled_r   <= 1'b0;
      sweep_act_r  <= 1'b1;
      sweep_mode_r <= tcw_pkg::SWEEP_INIT;
      ptr_r        <= '0;
      wb_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      scrolled_r   <= scrolled_nxt;
      sweep_act_r  <= sweep_act_nxt;
      sweep_mode_r <= sweep_mode_nxt;
      ptr_r        <= ptr_nxt;
      wb_valid_r   <= sweep_act_r;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wb_addr_r   <= ptr_r;
    wb_bottom_r <= (ptr_r >= TOP_A);
    if (cmd.latch_in) begin
      cmd_r   <= in_cmd;
      code_r  <= in_char_code;
      index_r <= in_cell_index;
    end
    if (cmd.load_out) begin
      cell_word_r    <= (cmd_r == tcw_pkg::CMD_READ && idx_ok) ? rdata_r : 16'h0000;
      cursor_row_r   <= 5'(row_r);
      cursor_col_r   <= 7'(col_r);
      out_scrolled_r <= scrolled_r;
    end
  end

  // Cell store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cells_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= cells_r[rd_addr];
    end
  end

  assign st.cmd          = cmd_r;
  assign st.is_newline   = (code_r == tcw_pkg::CODE_NEWLINE);
  assign st.is_backspace = (code_r == tcw_pkg::CODE_BACKSPACE);
  assign st.col_zero     = (col_r == '0);
  assign st.row_zero     = (row_r == '0);
  assign st.col_full     = (col_r == COL_FULL);
  assign st.row_last     = (row_r == ROW_LAST);
  assign st.sweep_busy   = sweep_act_r | wb_valid_r;
  assign st.out_free     = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_cell_word  = cell_word_r;
  assign out_cursor_row = cursor_row_r;
  assign out_cursor_col = cursor_col_r;
  assign out_scrolled   = out_scrolled_r;

endmodule

`default_nettype wire

[hw/rtl/text_console_writer.sv]
// Text console writer: a ROWS x COLUMNS screen of 16-bit cells (attribute
// byte high, character byte low) with a cursor, scrolling and clearing.
//
// Input channel (in_valid / in_stall): one item is a command in in_cmd with
// in_char_code for put character and in_cell_index for read cell. Result
// channel (out_valid / out_stall): exactly one item per command, giving the
// cell read, the cursor after the command and whether the screen scrolled.
// One command is worked on at a time. Read cell, a newline without scroll,
// backspace at the home position and an unused command go from execute
// straight to the result; a printable byte or backspace first reads and
// then rewrites the cursor cell. The block goes back to idle and takes the
// next item once the result is loaded. Scroll and clear walk every cell,
// one cell per cycle through the store's read and write ports.
// After reset the store is zeroed by the same sweep while in_stall stays
// high; the cursor starts at home. A finished result waits in an output
// register while out_stall is high; the block still takes the next item
// and holds its result back until the register frees up.
// Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
`default_nettype none

module text_console_writer #(
  parameter int unsigned COLUMNS = tcw_pkg::TCW_COLUMNS,
  parameter int unsigned ROWS    = tcw_pkg::TCW_ROWS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [10:0] in_cell_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_cell_word,
  output logic [4:0]       out_cursor_row,
  output logic [6:0]       out_cursor_col,
  output logic             out_scrolled
);

  tcw_pkg::tcw_cmd_t    cmd;
  tcw_pkg::tcw_status_t st;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_cmd         (in_cmd),
    .in_char_code   (in_char_code),
    .in_cell_index  (in_cell_index),
    .cmd            (cmd),
    .st             (st),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_cell_word  (out_cell_word),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .out_scrolled   (out_scrolled)
  );

endmodule

`default_nettype wire
